// ===== sv/srm_pkg.sv =====
// srm_pkg: shared constants and helper functions of the reverb mixer.
// No dependencies.
package srm_pkg;

  localparam int MaxDelayDef   = 16384;
  localparam int SampleBitsDef = 24;
  localparam int LineBitsDef   = 32;

  localparam int QShift = 14;
  localparam int QHalf  = 8192;
  localparam int ApGain = 11469;

  // Register indexes
  localparam logic [1:0] RegMode = 2'd0;
  localparam logic [1:0] RegDry  = 2'd1;
  localparam logic [1:0] RegWet  = 2'd2;

  localparam logic [15:0] DryReset = 16'd16384;
  localparam logic [15:0] WetReset = 16'd4096;

  // Seven lines per bank: allpass 0..2, combs 3..6
  localparam int NumLines = 7;

  function automatic int fb_len(input int i);
    case (i)
      0: fb_len = 661;
      1: fb_len = 257;
      2: fb_len = 71;
      3: fb_len = 3229;
      4: fb_len = 3079;
      5: fb_len = 3943;
      default: fb_len = 4327;
    endcase
  endfunction

  function automatic int ff_len(input int i);
    case (i)
      0: ff_len = 2017;
      1: ff_len = 647;
      2: ff_len = 137;
      3: ff_len = 9209;
      4: ff_len = 9601;
      5: ff_len = 10369;
      default: ff_len = 11131;
    endcase
  endfunction

  function automatic int fb_gain(input int i);
    case (i)
      0: fb_gain = 12009;
      1: fb_gain = 13140;
      2: fb_gain = 12337;
      default: fb_gain = 12009;
    endcase
  endfunction

  function automatic int ff_gain(input int i);
    case (i)
      0: ff_gain = 12157;
      1: ff_gain = 12009;
      2: ff_gain = 11715;
      default: ff_gain = 11420;
    endcase
  endfunction

  function automatic int cap_len(input int d, input int m);
    cap_len = (d < m) ? d : m;
  endfunction

endpackage

// ===== sv/srm_line.sv =====
// srm_line: one delay-line stage (allpass or comb) with a private memory.
// Depends on srm_pkg. Comb: read, multiply, combine/write;
// allpass adds a second multiply stage.
module srm_line
  import srm_pkg::*;
#(
  parameter int Len      = 16,
  parameter int LineBits = 32,
  parameter int Gain     = 11469,
  parameter bit IsAp     = 1'b1,
  parameter bit Feedback = 1'b1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       vld_i,
  input  logic signed [LineBits-1:0] x_i,
  output logic signed [LineBits-1:0] y_o
);
  localparam int AW = (Len > 1) ? $clog2(Len) : 1;
  localparam int PW = LineBits + 16;

  logic signed [LineBits-1:0] mem [Len];
  logic [AW-1:0] pos_q, pos_d;
  logic          full_q;
  logic [AW-1:0] wa_q;
  logic          we_q;
  logic signed [LineBits-1:0] wd_q;

  // stage 1: registered read
  logic signed [LineBits-1:0] d1_q, x1_q;
  logic                       z1_q;
  logic [AW-1:0]              a1_q;
  logic                       v1_q;
  // stage 2: multiply delayed word
  logic signed [LineBits-1:0] d2_q, x2_q;
  logic signed [PW-1:0]       p2_q;
  logic [AW-1:0]              a2_q;
  logic                       v2_q;
  // stage 3 (allpass): second product
  logic signed [LineBits-1:0] d3_q;
  logic signed [PW-1:0]       p3_q;

  function automatic logic signed [LineBits-1:0] sat_l(input logic signed [PW:0] v);
    logic signed [PW:0] hi, lo;
    hi = (PW+1)'((64'sd1 <<< (LineBits-1)) - 1);
    lo = -hi - 1;
    sat_l = (v > hi) ? hi[LineBits-1:0] : ((v < lo) ? lo[LineBits-1:0] : v[LineBits-1:0]);
  endfunction

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = p + PW'(QHalf);
    rnd = t >>> QShift;
  endfunction

  assign pos_d = (32'(pos_q) + 1 < Len) ? pos_q + AW'(1) : '0;

  always_ff @(posedge clk_i) begin
    if (en_i && we_q) mem[wa_q] <= wd_q;
  end

  // full_q: set once the position has wrapped; before that the word at the read position is unwritten and reads as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      full_q <= 1'b0;
      v1_q <= 1'b0; v2_q <= 1'b0; we_q <= 1'b0;
    end else if (en_i) begin
      if (vld_i) begin
        pos_q <= pos_d;
        if (pos_d == '0) full_q <= 1'b1;
      end
      v1_q <= vld_i; v2_q <= v1_q;
      we_q <= v2_q;
    end
  end

  logic signed [LineBits-1:0] d1;
  logic signed [LineBits-1:0] vv2, y2;
  assign d1  = z1_q ? '0 : d1_q;
  assign vv2 = sat_l((PW+1)'(x2_q) - (PW+1)'(rnd(p2_q)));
  assign y2  = sat_l((PW+1)'(x2_q) + (PW+1)'(rnd(p2_q)));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q <= mem[pos_q]; z1_q <= !full_q; x1_q <= x_i; a1_q <= pos_q;
      d2_q <= d1; x2_q <= x1_q; a2_q <= a1_q;
      p2_q <= PW'(d1) * PW'(Gain);
      d3_q <= d2_q;
      p3_q <= PW'(vv2) * PW'(Gain);
      wa_q <= a2_q;
      wd_q <= IsAp ? vv2 : (Feedback ? y2 : x2_q);
      y_o  <= IsAp ? sat_l((PW+1)'(d3_q) + (PW+1)'(rnd(p3_q))) : y2;
    end
  end
  // The write to a word follows its read through a1_q, a2_q and wa_q; lines are far longer than that pipeline.
endmodule

// ===== sv/schroeder_reverb_mixer.sv =====
// Channel  Dir  Width  Fields
// s_axis   in   24     voice_sample
// m_axis   out  48     left_sample [23:0], right_sample [47:24]
// apb      in   32     reverb_mode, dry_gain, wet_gain at 0x0, 0x4, 0x8
//
// One request per cycle unless m_axis stalls; a result shows on m_axis once its request
// has passed three allpass lines, a comb stage, the wet sum, the gain products and
// the output register.
// A stall freezes the whole pipeline; the output register holds its result.
// Reset clears the line positions and valid bits; each line reads zero until its position
// first wraps, so the line memories behave as cleared without a clearing pass.
// Top level: depends on srm_pkg and srm_line.
module schroeder_reverb_mixer
  import srm_pkg::*;
#(
  parameter int MaxDelay   = MaxDelayDef,
  parameter int SampleBits = SampleBitsDef,
  parameter int LineBits   = LineBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [SampleBits-1:0]   s_axis_tdata,   // voice_sample
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [2*SampleBits-1:0] m_axis_tdata,   // left_sample, right_sample
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [3:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  // valid bits reach index 16, the dry sample 15, the mode bit 14
  localparam int Depth = 17;

  logic        mode_q;
  logic [15:0] dry_q, wet_q;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0; dry_q <= DryReset; wet_q <= WetReset;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        RegMode: mode_q <= pwdata[0];
        RegDry:  dry_q  <= pwdata[15:0];
        RegWet:  wet_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end
  always_comb begin
    case (paddr[3:2])
      RegMode: prdata = {31'd0, mode_q};
      RegDry:  prdata = {16'd0, dry_q};
      RegWet:  prdata = {16'd0, wet_q};
      default: prdata = '0;
    endcase
  end

  // Pipeline enable: advance unless output holds an unaccepted result.
  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  // valid / mode / dry sample travel alongside
  logic [Depth-1:0]                 vld_sr_q;
  logic [Depth-3:0]                 mode_sr_q;
  logic signed [SampleBits-1:0]     dry_sr_q [Depth-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_sr_q <= '0;
    else if (en) vld_sr_q <= {vld_sr_q[Depth-2:0], in_fire};
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      mode_sr_q <= {mode_sr_q[Depth-4:0], mode_q};
      dry_sr_q[0] <= s_axis_tdata;
      for (int k = 1; k < Depth-1; k++) dry_sr_q[k] <= dry_sr_q[k-1];
    end
  end

  logic signed [LineBits-1:0] x_in;
  assign x_in = LineBits'($signed(s_axis_tdata));

  // allpass chains, four stages each per line
  logic signed [LineBits-1:0] fa [4];
  logic signed [LineBits-1:0] ea [4];
  assign fa[0] = x_in;
  assign ea[0] = x_in;
  logic [2:0] vfa, vea;
  assign vfa = {vld_sr_q[7] && !mode_sr_q[7], vld_sr_q[3] && !mode_sr_q[3],
                in_fire && !mode_q};
  assign vea = {vld_sr_q[7] && mode_sr_q[7], vld_sr_q[3] && mode_sr_q[3],
                in_fire && mode_q};

  for (genvar g = 0; g < 3; g++) begin : g_ap
    srm_line #(.Len(cap_len(fb_len(g), MaxDelay)), .LineBits(LineBits),
               .Gain(ApGain), .IsAp(1'b1), .Feedback(1'b0))
      u_fb (.clk_i, .rst_ni, .en_i(en), .vld_i(vfa[g]), .x_i(fa[g]), .y_o(fa[g+1]));
    srm_line #(.Len(cap_len(ff_len(g), MaxDelay)), .LineBits(LineBits),
               .Gain(ApGain), .IsAp(1'b1), .Feedback(1'b0))
      u_ff (.clk_i, .rst_ni, .en_i(en), .vld_i(vea[g]), .x_i(ea[g]), .y_o(ea[g+1]));
  end

  // combs enter at valid index 11, after the allpass chains; comb outputs are valid at index 14
  logic signed [LineBits-1:0] fc [4];
  logic signed [LineBits-1:0] ec [4];
  logic vfc, vec;
  assign vfc = vld_sr_q[11] && !mode_sr_q[11];
  assign vec = vld_sr_q[11] && mode_sr_q[11];

  for (genvar g = 0; g < 4; g++) begin : g_cb
    srm_line #(.Len(cap_len(fb_len(g+3), MaxDelay)), .LineBits(LineBits),
               .Gain(fb_gain(g)), .IsAp(1'b0), .Feedback(1'b1))
      u_fb (.clk_i, .rst_ni, .en_i(en), .vld_i(vfc), .x_i(fa[3]), .y_o(fc[g]));
    srm_line #(.Len(cap_len(ff_len(g+3), MaxDelay)), .LineBits(LineBits),
               .Gain(ff_gain(g)), .IsAp(1'b0), .Feedback(1'b0))
      u_ff (.clk_i, .rst_ni, .en_i(en), .vld_i(vec), .x_i(ea[3]), .y_o(ec[g]));
  end

  // wet sums (index 14: comb outputs valid)
  function automatic logic signed [LineBits-1:0] satw(input logic signed [LineBits+2:0] v);
    logic signed [LineBits+2:0] hi, lo;
    hi = (LineBits+3)'((64'sd1 <<< (LineBits-1)) - 1);
    lo = -hi - 1;
    satw = (v > hi) ? hi[LineBits-1:0] : ((v < lo) ? lo[LineBits-1:0] : v[LineBits-1:0]);
  endfunction

  logic signed [LineBits+2:0] s0, s1, se;
  assign s0 = (LineBits+3)'(fc[0]) + (LineBits+3)'(fc[2]);
  assign s1 = (LineBits+3)'(fc[1]) + (LineBits+3)'(fc[3]);
  assign se = (LineBits+3)'(ec[0]) + (LineBits+3)'(ec[1]) + (LineBits+3)'(ec[2])
            + (LineBits+3)'(ec[3]);

  logic signed [LineBits-1:0] wl_q, wr_q;
  localparam int MW = LineBits + 20;
  logic signed [MW-1:0] pdl_q, pwl_q, pwr_q;
  logic signed [SampleBits-1:0] ol_q, or_q;
  logic ov_q;

  function automatic logic signed [SampleBits-1:0] sat_s(input logic signed [MW:0] v);
    logic signed [MW:0] hi, lo, t;
    t = v >>> QShift;
    hi = (MW+1)'((64'sd1 <<< (SampleBits-1)) - 1);
    lo = -hi - 1;
    sat_s = (t > hi) ? hi[SampleBits-1:0] : ((t < lo) ? lo[SampleBits-1:0] : t[SampleBits-1:0]);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en) begin
      wl_q <= mode_sr_q[14] ? satw(se) : satw(s0 + s1);
      wr_q <= mode_sr_q[14] ? satw(se) : satw(s0 - s1);
      pdl_q <= MW'(dry_sr_q[15]) * MW'($signed({1'b0, dry_q})) + MW'(QHalf);
      pwl_q <= MW'(wl_q) * MW'($signed({1'b0, wet_q}));
      pwr_q <= MW'(wr_q) * MW'($signed({1'b0, wet_q}));
    end
    if (en) begin
      ol_q <= sat_s((MW+1)'(pdl_q) + (MW+1)'(pwl_q));
      or_q <= sat_s((MW+1)'(pdl_q) + (MW+1)'(pwr_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) ov_q <= 1'b0;
    else if (en) ov_q <= vld_sr_q[16];
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = {or_q, ol_q};
endmodule

// ===== sv/srm_checker.sv =====
// srm_checker: port-level checks for the reverb mixer, bound to the top level.
// Depends on schroeder_reverb_mixer.
module srm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic pready
);
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("result dropped");
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready) else $error("accept on stall");
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready) else $error("pready low");
endmodule

bind schroeder_reverb_mixer srm_checker u_chk (.clk_i, .rst_ni, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .pready);
